// ===== rtl/wavhp_pkg.sv =====
package wavhp_pkg;

  // marker scan limit, in file bytes
  localparam int HEADER_WINDOW = 262144;
  localparam int POS_W         = $clog2(HEADER_WINDOW) + 1;

  // frame size is channels (16 bits) times whole bytes per sample (13 bits)
  localparam int FSZ_W = 29;
  localparam int DIV_W = 32;
  localparam int CNT_W = $clog2(DIV_W);

  // marker bytes
  localparam logic [23:0] MARK_RIF = {8'h52, 8'h49, 8'h46};  // "RIF"
  localparam logic [7:0]  MARK_F   = 8'h46;                   // "F"
  localparam logic [15:0] MARK_FM  = {8'h66, 8'h6D};          // "fm"
  localparam logic [7:0]  MARK_T   = 8'h74;                   // "t"
  localparam logic [23:0] MARK_DAT = {8'h64, 8'h61, 8'h74};  // "dat"
  localparam logic [7:0]  MARK_A   = 8'h61;                   // "a"

  // field ids
  localparam logic [3:0] FID_RIFF_SIZE = 4'd0;
  localparam logic [3:0] FID_FORMAT    = 4'd1;
  localparam logic [3:0] FID_FMT_SIZE  = 4'd2;
  localparam logic [3:0] FID_AUDIO     = 4'd3;
  localparam logic [3:0] FID_CHAN      = 4'd4;
  localparam logic [3:0] FID_RATE      = 4'd5;
  localparam logic [3:0] FID_BRATE     = 4'd6;
  localparam logic [3:0] FID_ALIGN     = 4'd7;
  localparam logic [3:0] FID_BITS      = 4'd8;
  localparam logic [3:0] FID_DATA_SIZE = 4'd9;
  localparam logic [3:0] FID_START     = 4'd10;
  localparam logic [3:0] FID_FRAMES    = 4'd11;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_MARKER  = 2'd1;
  localparam logic [1:0] ST_EARLY_END  = 2'd2;
  localparam logic [1:0] ST_ZERO_FRAME = 2'd3;

  typedef enum logic [3:0] {
    P_SCAN_RIFF, P_RIFF_SIZE, P_FORMAT, P_SCAN_FMT, P_SKIP, P_FMT_SIZE,
    P_AUDIO, P_CHAN, P_RATE, P_BRATE, P_ALIGN, P_BITS, P_SCAN_DATA,
    P_DATA_SIZE, P_DONE
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EARLY, S_START, S_DIV, S_FRAMES
  } ctrl_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_byte;
    logic       last_byte;
  } wav_in_t;

  typedef struct packed {
    logic [3:0]  field_id;
    logic [31:0] field_value;
    logic [1:0]  status;
    logic        done_res;
  } wav_res_t;

  // field length in bytes, 0 for phases that read no field
  function automatic logic [2:0] len_of(input phase_t ph);
    case (ph)
      P_RIFF_SIZE, P_FORMAT, P_FMT_SIZE, P_RATE, P_BRATE, P_DATA_SIZE: len_of = 3'd4;
      P_AUDIO, P_CHAN, P_ALIGN, P_BITS:                                len_of = 3'd2;
      default:                                                         len_of = 3'd0;
    endcase
  endfunction

  // id of the field expected or being read
  function automatic logic [3:0] id_of(input phase_t ph);
    case (ph)
      P_SCAN_RIFF, P_RIFF_SIZE:         id_of = FID_RIFF_SIZE;
      P_FORMAT:                         id_of = FID_FORMAT;
      P_SCAN_FMT, P_SKIP, P_FMT_SIZE:   id_of = FID_FMT_SIZE;
      P_AUDIO:                          id_of = FID_AUDIO;
      P_CHAN:                           id_of = FID_CHAN;
      P_RATE:                           id_of = FID_RATE;
      P_BRATE:                          id_of = FID_BRATE;
      P_ALIGN:                          id_of = FID_ALIGN;
      P_BITS:                           id_of = FID_BITS;
      P_SCAN_DATA, P_DATA_SIZE:         id_of = FID_DATA_SIZE;
      default:                          id_of = FID_FRAMES;
    endcase
  endfunction

endpackage

// ===== rtl/wav_header_parser_core.sv =====
// riff/wave header parser, one file byte per input beat
//
// byte channel: byte_valid/byte_ready/byte_data. first_byte restarts the parser,
// last_byte marks the final byte available. res channel: res_valid/res_ready/
// res_data, one beat per parsed field (id, value, status, done flag).
// throughput: one byte per cycle while results drain; a byte that makes
// two results (field plus early end) holds byte_ready low until the
// second is loaded. the byte that completes the data size makes three
// results: data size, data start, and frame count. frame count comes from
// one shift-subtract divider, one quotient bit per cycle; byte_ready stays
// low through the frame size multiply, 32 divide steps and result loads.
// a field result is registered and shows in the cycle after its byte.
// a one-beat result register sits on the output; if the receiver stalls,
// byte_ready drops until that beat is taken, no result is ever dropped.
// reset: synchronous, the parser scans for the RIFF marker from offset 0,
// output register empty. after a done result, bytes are swallowed until
// one arrives with first_byte set.
module wav_header_parser_core
  import wavhp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     byte_valid,
  output logic     byte_ready,
  input  wav_in_t  byte_data,
  output logic     res_valid,
  input  logic     res_ready,
  output wav_res_t res_data
);

  // sequencer and parse state
  ctrl_t              ctrl, ctrl_next;
  phase_t             phase;
  logic [1:0]         byte_in_field;
  logic [31:0]        field_accumulator;
  logic [23:0]        recent_bytes;
  logic [1:0]         recent_valid;
  logic [POS_W-1:0]   position;
  logic [15:0]        channel_count;
  logic [15:0]        sample_bits;

  // pending results and divider
  logic [3:0]         pend_id;
  logic [POS_W-1:0]   data_start;
  logic [FSZ_W-1:0]   fsz;
  logic [DIV_W-1:0]   rem;
  logic [DIV_W-1:0]   quo;
  logic [CNT_W-1:0]   div_cnt;

  logic slot_free;
  logic accept;

  // per-byte parse results
  phase_t           ph_e, ph_a, ph_n;
  logic [1:0]       bif_e, bif_n;
  logic [31:0]      acc_e, acc_n, acc_or;
  logic [23:0]      rb_e, rb_n;
  logic [1:0]       rv_e, rv_n;
  logic [POS_W-1:0] pos_e, pos_n;
  logic [15:0]      chan_e, chan_n, bits_e, bits_n;
  logic             hit;
  logic [2:0]       flen;
  logic [31:0]      fval;
  logic             r0_valid;
  wav_res_t         r0;
  logic             early_pend;
  logic             data_fin;
  logic             do_advance;

  // output load
  logic     res_load;
  wav_res_t res_next;

  // divider step
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_diff;
  logic             rem_ge;

  assign slot_free  = !res_valid || res_ready;
  assign byte_ready = (ctrl == S_IDLE) && slot_free;
  assign accept     = byte_valid && byte_ready;

  // ---------------------------------------------------------------
  // byte parse: everything one accepted byte does to the parse state
  // ---------------------------------------------------------------
  always_comb begin
    // first_byte behaves as a reset in front of the byte
    ph_e   = byte_data.first_byte ? P_SCAN_RIFF : phase;
    bif_e  = byte_data.first_byte ? 2'd0 : byte_in_field;
    acc_e  = byte_data.first_byte ? 32'd0 : field_accumulator;
    rb_e   = byte_data.first_byte ? 24'd0 : recent_bytes;
    rv_e   = byte_data.first_byte ? 2'd0 : recent_valid;
    pos_e  = byte_data.first_byte ? '0 : position;
    chan_e = byte_data.first_byte ? 16'd0 : channel_count;
    bits_e = byte_data.first_byte ? 16'd0 : sample_bits;

    ph_a       = ph_e;
    bif_n      = bif_e;
    acc_n      = acc_e;
    rb_n       = rb_e;
    rv_n       = rv_e;
    pos_n      = pos_e;
    chan_n     = chan_e;
    bits_n     = bits_e;
    r0_valid   = 1'b0;
    r0         = '0;
    early_pend = 1'b0;
    data_fin   = 1'b0;
    do_advance = 1'b0;
    flen       = len_of(ph_e);
    acc_or     = acc_e | (32'(byte_data.byte_value) << {bif_e, 3'b000});
    fval       = (flen == 3'd2) ? {16'd0, acc_or[15:0]} : acc_or;

    case (ph_e)
      P_SCAN_RIFF: hit = (rv_e == 2'd3) && (rb_e == MARK_RIF)
                         && (byte_data.byte_value == MARK_F);
      P_SCAN_FMT:  hit = (rv_e != 2'd0) && (rv_e != 2'd1) && (rb_e[15:0] == MARK_FM)
                         && (byte_data.byte_value == MARK_T);
      P_SCAN_DATA: hit = (rv_e == 2'd3) && (rb_e == MARK_DAT)
                         && (byte_data.byte_value == MARK_A);
      default:     hit = 1'b0;
    endcase

    if (ph_e != P_DONE) begin
      case (ph_e)
        P_SCAN_RIFF, P_SCAN_FMT, P_SCAN_DATA: begin
          if (hit && pos_e < POS_W'(HEADER_WINDOW)) begin
            do_advance = 1'b1;
          end else if (pos_e >= POS_W'(HEADER_WINDOW - 1)) begin
            r0_valid = 1'b1;
            r0       = '{field_id: id_of(ph_e), field_value: 32'd0,
                         status: ST_NO_MARKER, done_res: 1'b1};
            ph_a     = P_DONE;
          end else begin
            rb_n = {rb_e[15:0], byte_data.byte_value};
            if (rv_e != 2'd3) begin
              rv_n = rv_e + 2'd1;
            end
          end
        end
        P_SKIP: begin
          do_advance = 1'b1;
        end
        default: begin
          acc_n = acc_or;
          if ({1'b0, bif_e} + 3'd1 >= flen) begin
            r0_valid = 1'b1;
            r0       = '{field_id: id_of(ph_e), field_value: fval,
                         status: ST_OK, done_res: 1'b0};
            if (ph_e == P_CHAN) begin
              chan_n = fval[15:0];
            end
            if (ph_e == P_BITS) begin
              bits_n = fval[15:0];
            end
            if (ph_e == P_DATA_SIZE) begin
              data_fin = 1'b1;
              ph_a     = P_DONE;
            end else begin
              do_advance = 1'b1;
            end
          end else begin
            bif_n = bif_e + 2'd1;
          end
        end
      endcase

      if (do_advance) begin
        ph_a  = phase_t'(ph_e + 4'd1);
        bif_n = 2'd0;
        acc_n = 32'd0;
        rb_n  = 24'd0;
        rv_n  = 2'd0;
      end
      pos_n = pos_e + POS_W'(1);
    end

    // early end of stream goes after any field result of this byte
    ph_n = ph_a;
    if (byte_data.last_byte && ph_a != P_DONE) begin
      ph_n = P_DONE;
      if (r0_valid) begin
        early_pend = 1'b1;
      end else begin
        r0_valid = 1'b1;
        r0       = '{field_id: id_of(ph_a), field_value: 32'd0,
                     status: ST_EARLY_END, done_res: 1'b1};
      end
    end
  end

  // ---------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------
  always_comb begin
    ctrl_next = ctrl;
    case (ctrl)
      S_IDLE: begin
        if (accept && data_fin) begin
          ctrl_next = S_START;
        end else if (accept && early_pend) begin
          ctrl_next = S_EARLY;
        end
      end
      S_EARLY: begin
        if (slot_free) begin
          ctrl_next = S_IDLE;
        end
      end
      S_START: begin
        if (slot_free) begin
          ctrl_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_cnt == CNT_W'(DIV_W - 1)) begin
          ctrl_next = S_FRAMES;
        end
      end
      S_FRAMES: begin
        if (slot_free) begin
          ctrl_next = S_IDLE;
        end
      end
      default: ctrl_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------
  // sequencer: result register loads
  // ---------------------------------------------------------------
  always_comb begin
    res_load = 1'b0;
    res_next = '0;
    case (ctrl)
      S_IDLE: begin
        if (accept && r0_valid) begin
          res_load = 1'b1;
          res_next = r0;
        end
      end
      S_EARLY: begin
        if (slot_free) begin
          res_load = 1'b1;
          res_next = '{field_id: pend_id, field_value: 32'd0,
                       status: ST_EARLY_END, done_res: 1'b1};
        end
      end
      S_START: begin
        if (slot_free) begin
          res_load = 1'b1;
          res_next = '{field_id: FID_START, field_value: 32'(data_start),
                       status: ST_OK, done_res: 1'b0};
        end
      end
      S_FRAMES: begin
        if (slot_free) begin
          res_load = 1'b1;
          if (fsz == '0) begin
            res_next = '{field_id: FID_FRAMES, field_value: 32'd0,
                         status: ST_ZERO_FRAME, done_res: 1'b1};
          end else begin
            res_next = '{field_id: FID_FRAMES, field_value: quo,
                         status: ST_OK, done_res: 1'b1};
          end
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // divider step: restoring shift-subtract, one quotient bit a cycle
  assign rem_sh   = {rem, quo[DIV_W-1]};
  assign rem_diff = rem_sh - (DIV_W + 1)'(fsz);
  assign rem_ge   = rem_sh >= (DIV_W + 1)'(fsz);

  // ---------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl              <= S_IDLE;
      phase             <= P_SCAN_RIFF;
      byte_in_field     <= 2'd0;
      field_accumulator <= 32'd0;
      recent_bytes      <= 24'd0;
      recent_valid      <= 2'd0;
      position          <= '0;
      channel_count     <= 16'd0;
      sample_bits       <= 16'd0;
      res_valid         <= 1'b0;
      div_cnt           <= '0;
    end else begin
      ctrl <= ctrl_next;
      if (accept) begin
        phase             <= ph_n;
        byte_in_field     <= bif_n;
        field_accumulator <= acc_n;
        recent_bytes      <= rb_n;
        recent_valid      <= rv_n;
        position          <= pos_n;
        channel_count     <= chan_n;
        sample_bits       <= bits_n;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (ctrl == S_START) begin
        div_cnt <= '0;
      end else if (ctrl == S_DIV) begin
        div_cnt <= div_cnt + CNT_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_data <= res_next;
    end
    if (accept) begin
      pend_id    <= id_of(ph_a);
      data_start <= pos_e + POS_W'(1);
      quo        <= fval;  // dividend, only used after the data size field
    end
    if (ctrl == S_START) begin
      // frame size = channels * whole bytes per sample
      fsz <= FSZ_W'(channel_count) * FSZ_W'(sample_bits[15:3]);
      rem <= '0;
    end else if (ctrl == S_DIV) begin
      rem <= rem_ge ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], rem_ge};
    end
  end

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.done_res |-> phase == P_DONE)
    else $error("done result shown while parse not finished");

  a_err_value: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status != ST_OK |-> res_data.field_value == 32'd0
      && res_data.done_res)
    else $error("error result with value or without done");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    ctrl == S_DIV && div_cnt == CNT_W'(DIV_W - 1) |=> ctrl == S_FRAMES)
    else $error("divider did not hand over after last step");

  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    ctrl == S_START && slot_free |=> ctrl == S_DIV && div_cnt == '0)
    else $error("divider not started cleanly");

endmodule

// ===== bench/tb_wav_header_parser_core.sv =====
module tb_wav_header_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  import wavhp_pkg::*;

  // run shape
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int RANDOM_ITEMS   = 200;
  localparam int CALM_ITEMS     = 50;    // tail of the random part with no idling
  localparam int SETTLE_CYCLES  = 40;    // frame-count divide plus output register

  localparam logic [31:0] TAG_WAVE = 32'h45564157;  // "WAVE", first byte in 7:0
  localparam logic [7:0]  FMT_PAD  = 8'h20;         // the space after "fmt"

  // field id reported in each parser phase, indexed by phase_t
  localparam logic [3:0] PHASE_FID [15] = '{
    FID_RIFF_SIZE, FID_RIFF_SIZE, FID_FORMAT, FID_FMT_SIZE, FID_FMT_SIZE,
    FID_FMT_SIZE, FID_AUDIO, FID_CHAN, FID_RATE, FID_BRATE, FID_ALIGN,
    FID_BITS, FID_DATA_SIZE, FID_DATA_SIZE, FID_FRAMES
  };
  // bytes per field in each phase, zero where no field is read
  localparam int PHASE_NBYTES [15] = '{0, 4, 4, 0, 0, 4, 2, 2, 4, 4, 2, 2, 0, 4, 0};

  // one header's content plus the padding around its markers
  typedef struct {
    logic [31:0] riff_size;
    logic [31:0] tag;
    logic [7:0]  fmt_pad;
    logic [31:0] fmt_size;
    logic [15:0] audio;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [31:0] brate;
    logic [15:0] align;
    logic [15:0] bits;
    logic [31:0] data_size;
    int          pre_junk;   // bytes before "RIFF"
    int          mid_junk;   // bytes between format tag and "fmt"
    int          post_junk;  // bytes between bits per sample and "data"
    int          trailer;    // sample bytes after the header, ignored by the block
  } wav_hdr_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     byte_valid;
  logic     byte_ready;
  wav_in_t  byte_data;
  logic     res_valid;
  logic     res_ready;
  wav_res_t res_data;

  // parser shadow state
  phase_t      prs_phase;
  int          prs_nbyte;
  logic [31:0] prs_acc;
  logic [23:0] prs_tail;     // last three scanned bytes, oldest on top
  int          prs_tail_n;
  int unsigned prs_pos;      // file offset of the next byte
  logic [15:0] prs_chans;
  logic [15:0] prs_bits;

  wav_res_t   hdr_expect_q[$];
  logic [7:0] wav_bytes[$];

  bit snd_idle;
  bit rcv_idle;
  bit hold_req;
  int items_done;
  int err_count;
  int quiet_cycles;

  always #4 clk = ~clk;

  wav_header_parser_core u_top (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
  );

  // ---------------------------------------------------------------------------
  // header parser prediction
  // ---------------------------------------------------------------------------

  function automatic void parser_restart();
    prs_phase  = P_SCAN_RIFF;
    prs_nbyte  = 0;
    prs_acc    = '0;
    prs_tail   = '0;
    prs_tail_n = 0;
    prs_pos    = 0;
    prs_chans  = '0;
    prs_bits   = '0;
  endfunction

  function automatic void next_phase();
    prs_phase  = phase_t'(prs_phase + 1);
    prs_nbyte  = 0;
    prs_acc    = '0;
    prs_tail   = '0;
    prs_tail_n = 0;
  endfunction

  function automatic void queue_field(logic [3:0] id, logic [31:0] val, logic [1:0] st,
                                      logic done);
    wav_res_t r;
    r.field_id    = id;
    r.field_value = val;
    r.status      = st;
    r.done_res    = done;
    hdr_expect_q.push_back(r);
  endfunction

  // returns 0 when the byte is swallowed after a finished header
  function automatic bit parse_byte(wav_in_t d);
    logic        hit;
    logic [31:0] v;
    logic [31:0] fsz;
    int          nb;
    if (d.first_byte)
      parser_restart();
    if (prs_phase == P_DONE)
      return 1'b0;
    case (prs_phase)
      P_SCAN_RIFF, P_SCAN_FMT, P_SCAN_DATA: begin
        if (prs_phase == P_SCAN_RIFF)
          hit = prs_tail_n >= 3 && prs_tail == MARK_RIF && d.byte_value == MARK_F;
        else if (prs_phase == P_SCAN_FMT)
          hit = prs_tail_n >= 2 && prs_tail[15:0] == MARK_FM && d.byte_value == MARK_T;
        else
          hit = prs_tail_n >= 3 && prs_tail == MARK_DAT && d.byte_value == MARK_A;
        if (hit && prs_pos < HEADER_WINDOW) begin
          next_phase();
        end else if (prs_pos >= HEADER_WINDOW - 1) begin
          // scan ran out of window
          queue_field(PHASE_FID[int'(prs_phase)], '0, ST_NO_MARKER, 1'b1);
          prs_phase = P_DONE;
        end else begin
          prs_tail = {prs_tail[15:0], d.byte_value};
          if (prs_tail_n < 3)
            prs_tail_n++;
        end
      end
      P_SKIP: begin
        next_phase();
      end
      default: begin
        nb      = PHASE_NBYTES[int'(prs_phase)];
        prs_acc = prs_acc | (32'(d.byte_value) << (8 * prs_nbyte));
        if (prs_nbyte + 1 >= nb) begin
          v = (nb == 2) ? {16'h0000, prs_acc[15:0]} : prs_acc;
          queue_field(PHASE_FID[int'(prs_phase)], v, ST_OK, 1'b0);
          if (prs_phase == P_CHAN)
            prs_chans = v[15:0];
          else if (prs_phase == P_BITS)
            prs_bits = v[15:0];
          if (prs_phase == P_DATA_SIZE) begin
            // data size completes the header: start offset and frame count follow
            fsz = 32'(prs_chans) * 32'(prs_bits >> 3);
            queue_field(FID_START, prs_pos + 1, ST_OK, 1'b0);
            if (fsz == 0)
              queue_field(FID_FRAMES, '0, ST_ZERO_FRAME, 1'b1);
            else
              queue_field(FID_FRAMES, v / fsz, ST_OK, 1'b1);
            prs_phase = P_DONE;
          end else begin
            next_phase();
          end
        end else begin
          prs_nbyte++;
        end
      end
    endcase
    prs_pos++;
    // stream ended before the header did
    if (d.last_byte && prs_phase != P_DONE) begin
      queue_field(PHASE_FID[int'(prs_phase)], '0, ST_EARLY_END, 1'b1);
      prs_phase = P_DONE;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // file builders
  // ---------------------------------------------------------------------------

  function automatic void add_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++)
      wav_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void add_junk(int n);
    for (int i = 0; i < n; i++)
      wav_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  // lays out one file in wav_bytes, returns the length up to the data size
  function automatic int build_file(wav_hdr_t h);
    int hlen;
    wav_bytes.delete();
    add_junk(h.pre_junk);
    add_le({MARK_F, MARK_RIF[7:0], MARK_RIF[15:8], MARK_RIF[23:16]}, 4);
    add_le(h.riff_size, 4);
    add_le(h.tag, 4);
    add_junk(h.mid_junk);
    add_le({h.fmt_pad, MARK_T, MARK_FM[7:0], MARK_FM[15:8]}, 4);
    add_le(h.fmt_size, 4);
    add_le(h.audio, 2);
    add_le(h.chans, 2);
    add_le(h.rate, 4);
    add_le(h.brate, 4);
    add_le(h.align, 2);
    add_le(h.bits, 2);
    add_junk(h.post_junk);
    add_le({MARK_A, MARK_DAT[7:0], MARK_DAT[15:8], MARK_DAT[23:16]}, 4);
    add_le(h.data_size, 4);
    hlen = wav_bytes.size();
    add_junk(h.trailer);
    return hlen;
  endfunction

  // every field byte set to one value, no padding
  function automatic wav_hdr_t flat_hdr(logic [7:0] fill);
    wav_hdr_t h;
    h.riff_size = {4{fill}};
    h.tag       = {4{fill}};
    h.fmt_pad   = fill;
    h.fmt_size  = {4{fill}};
    h.audio     = {2{fill}};
    h.chans     = {2{fill}};
    h.rate      = {4{fill}};
    h.brate     = {4{fill}};
    h.align     = {2{fill}};
    h.bits      = {2{fill}};
    h.data_size = {4{fill}};
    h.pre_junk  = 0;
    h.mid_junk  = 0;
    h.post_junk = 0;
    h.trailer   = 0;
    return h;
  endfunction

  function automatic wav_hdr_t random_hdr();
    wav_hdr_t h;
    h.riff_size = $urandom;
    h.tag       = ($urandom_range(0, 3) == 0) ? 32'($urandom) : TAG_WAVE;
    h.fmt_pad   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : FMT_PAD;
    h.fmt_size  = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'd16;
    h.audio     = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd1;
    case ($urandom_range(0, 9))
      0:       h.chans = 16'd0;
      1:       h.chans = 16'($urandom);
      default: h.chans = 16'($urandom_range(1, 8));
    endcase
    h.rate  = $urandom;
    h.brate = $urandom;
    h.align = 16'($urandom);
    case ($urandom_range(0, 7))
      0:       h.bits = 16'($urandom_range(0, 7));  // under one byte per sample
      1:       h.bits = 16'($urandom);
      2:       h.bits = 16'd8;
      3:       h.bits = 16'd24;
      4:       h.bits = 16'd32;
      default: h.bits = 16'd16;
    endcase
    h.data_size = $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 4096));
    h.pre_junk  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    h.mid_junk  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    h.post_junk = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
    h.trailer   = $urandom_range(0, 6);
    return h;
  endfunction

  // ---------------------------------------------------------------------------
  // byte side
  // ---------------------------------------------------------------------------

  // one beat on the byte channel, then maybe an idle burst
  task automatic send_beat(logic [7:0] b, logic first, logic last);
    wav_in_t d;
    d.byte_value = b;
    d.first_byte = first;
    d.last_byte  = last;
    byte_valid <= 1'b1;
    byte_data  <= d;
    @(posedge clk);
    while (!byte_ready)
      @(posedge clk);
    void'(parse_byte(d));
    items_done++;
    if (snd_idle && $urandom_range(0, 5) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // sends the first n bytes of wav_bytes, last_byte set at index last_at
  task automatic play_file(int n, int last_at, bit with_first);
    for (int i = 0; i < n; i++)
      send_beat(wav_bytes[i], with_first && i == 0, i == last_at);
  endtask

  // sender goes quiet until every expected result has been taken
  task automatic wait_drain();
    byte_valid <= 1'b0;
    while (hdr_expect_q.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, one long hold-off on request, checking
  // ---------------------------------------------------------------------------

  task automatic report_bad(string what, wav_res_t got, wav_res_t want);
    err_count++;
    if (err_count <= 10)
      $display("%t %s: got id %0d val %h st %0d done %0b, want id %0d val %h st %0d done %0b",
               $realtime, what, got.field_id, got.field_value, got.status, got.done_res,
               want.field_id, want.field_value, want.status, want.done_res);
  endtask

  task automatic check_result(wav_res_t got);
    wav_res_t want;
    if (hdr_expect_q.size() == 0) begin
      want = '0;
      report_bad("unexpected result", got, want);
    end else begin
      want = hdr_expect_q.pop_front();
      if (got.field_id !== want.field_id || got.field_value !== want.field_value ||
          got.status !== want.status || got.done_res !== want.done_res)
        report_bad("result mismatch", got, want);
    end
  endtask

  initial begin : res_side
    int stall;
    int hold_cnt;
    stall     = 0;
    hold_cnt  = 0;
    res_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && res_ready)
        check_result(res_data);
      if (hold_req) begin
        // long hold-off so the output register fills and byte_ready drops
        if (hold_cnt < HOLD_CYCLES) begin
          hold_cnt++;
          res_ready <= 1'b0;
        end else begin
          hold_cnt  = 0;
          hold_req  = 1'b0;
          res_ready <= 1'b1;
        end
      end else if (stall > 0) begin
        stall--;
        res_ready <= 1'b0;
      end else if (rcv_idle && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 12) - 1;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // stop a hung run: no beat on either side for too long
  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_wav_header_parser_core NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // extremes, zero frame size, early end, restart mid header
  task automatic test_directed();
    wav_hdr_t h;
    int       hlen;
    // all-ones fields, no first_byte after reset, last_byte on the final size byte
    h    = flat_hdr(8'hFF);
    hlen = build_file(h);
    play_file(hlen, hlen - 1, 1'b0);
    // all-zero fields: zero channels, trailing sample bytes swallowed
    h         = flat_hdr(8'h00);
    h.trailer = 3;
    hlen      = build_file(h);
    play_file(wav_bytes.size(), -1, 1'b1);
    // one-byte file ends while scanning for the riff marker
    send_beat(8'h52, 1'b1, 1'b1);
    // stream ends on the byte that completes the channel count
    h       = flat_hdr(8'h5A);
    h.chans = 16'd2;
    hlen    = build_file(h);
    play_file(hlen - 20, hlen - 21, 1'b1);
    // half a header, then a restart; bits under 8 gives a zero frame size
    play_file(10, -1, 1'b1);
    h      = flat_hdr(8'h01);
    h.bits = 16'd7;
    hlen   = build_file(h);
    play_file(hlen, -1, 1'b1);
  endtask

  // receiver holds off while bytes keep coming, then the sender waits for all results
  task automatic test_backpressure();
    wav_hdr_t h;
    int       hlen;
    hold_req  = 1'b1;
    h         = random_hdr();
    h.trailer = 6;
    hlen      = build_file(h);
    play_file(wav_bytes.size(), -1, 1'b1);
    wait_drain();
    h    = random_hdr();
    hlen = build_file(h);
    play_file(hlen, -1, 1'b1);
  endtask

  // mostly well-formed headers with random content, plus cut, corrupt and noise files
  task automatic test_random();
    wav_hdr_t h;
    int       start_items;
    int       kind;
    int       hlen;
    int       cut;
    int       n;
    start_items = items_done;
    while (items_done - start_items < RANDOM_ITEMS) begin
      if (items_done - start_items >= RANDOM_ITEMS - CALM_ITEMS) begin
        snd_idle = 1'b0;
        rcv_idle = 1'b0;
      end else begin
        snd_idle = $urandom_range(0, 3) != 0;
        rcv_idle = $urandom_range(0, 3) != 0;
      end
      kind = $urandom_range(0, 9);
      h    = random_hdr();
      hlen = build_file(h);
      if (kind < 6) begin
        play_file(wav_bytes.size(), ($urandom_range(0, 2) == 0) ? hlen - 1 : -1, 1'b1);
      end else if (kind < 8) begin
        // cut short, with or without last_byte (the next file then restarts it)
        cut = $urandom_range(1, hlen);
        play_file(cut, $urandom_range(0, 1) ? cut - 1 : -1, 1'b1);
      end else if (kind == 8) begin
        wav_bytes[$urandom_range(0, hlen - 1)] = 8'($urandom_range(0, 255));
        play_file(wav_bytes.size(), -1, 1'b1);
      end else begin
        n = $urandom_range(1, 16);
        for (int i = 0; i < n; i++)
          send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                    $urandom_range(0, 7) == 0);
      end
      if ($urandom_range(0, 9) == 0)
        wait_drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst        <= 1'b1;
    byte_valid <= 1'b0;
    byte_data  <= '0;
    hold_req   = 1'b0;
    snd_idle   = 1'b1;
    rcv_idle   = 1'b1;
    items_done = 0;
    err_count  = 0;
    quiet_cycles = 0;
    parser_restart();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_backpressure();
    test_random();

    // let everything drain, then give the block time to show any stray beat
    snd_idle = 1'b0;
    rcv_idle = 1'b0;
    byte_valid <= 1'b0;
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && hdr_expect_q.size() == 0) begin
      $display("tb_wav_header_parser_core OK");
    end else begin
      $display("tb_wav_header_parser_core NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/wavhp_pkg.sv
rtl/wav_header_parser_core.sv
bench/tb_wav_header_parser_core.sv
